### hdl/vmu_pkg.sv
// ----------------------------------------------------------------------------
// Value mutation unit package
// Field widths, request layout, strategy and variant codes, byte swap helper.
// ----------------------------------------------------------------------------
package vmu_pkg;

	localparam int VALUE_W    = 64;
	localparam int PAGE_LOG_W = 5;
	localparam int FLIP_BITS  = 32;

	localparam logic [PAGE_LOG_W-1:0] PAGE_LOG_RESET = 5'd12;

	typedef enum logic [2:0] {
		KIND_TRUNC   = 3'd0,
		KIND_SET_MSB = 3'd1,
		KIND_ALIGN   = 3'd2,
		KIND_INVERT  = 3'd3,
		KIND_BSWAP   = 3'd4,
		KIND_FLIP    = 3'd5,
		KIND_DELTA   = 3'd6,
		KIND_EXTEND  = 3'd7
	} kind_t;

	// width variants for truncate and set-MSB
	localparam logic [2:0] VAR_W8  = 3'd0;
	localparam logic [2:0] VAR_W16 = 3'd1;
	localparam logic [2:0] VAR_W32 = 3'd2;

	// alignment variants
	localparam logic [2:0] ALIGN_PAGE_DOWN = 3'd0;
	localparam logic [2:0] ALIGN_PAGE_NEXT = 3'd1;
	localparam logic [2:0] ALIGN_LINE      = 3'd2;
	localparam logic [2:0] ALIGN_MISALIGN  = 3'd3;

	// byte swap variants
	localparam logic [2:0] SWAP_LOW32  = 3'd0;
	localparam logic [2:0] SWAP_FULL64 = 3'd1;

	// extend variants
	localparam logic [2:0] EXT_ZERO8  = 3'd0;
	localparam logic [2:0] EXT_ZERO16 = 3'd1;
	localparam logic [2:0] EXT_ZERO32 = 3'd2;
	localparam logic [2:0] EXT_SIGN8  = 3'd3;
	localparam logic [2:0] EXT_SIGN16 = 3'd4;
	localparam logic [2:0] EXT_SIGN32 = 3'd5;

	localparam logic [1:0] MISALIGN_NONE = 2'd3;

	// request payload, first member in the top bits so value lands at bit 0
	typedef struct packed {
		logic                subtract;
		logic [7:0]          delta;
		logic [4:0]          flip_bit;
		logic [1:0]          misalign_bit;
		logic [2:0]          variant;
		logic [VALUE_W-1:0]  value;
	} req_t;

	localparam int REQ_W       = $bits(req_t);
	localparam int IN_TDATA_W  = ((REQ_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = VALUE_W;
	localparam int IN_TUSER_W  = $bits(kind_t);

	function automatic logic [31:0] bswap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

### hdl/value_mutation_unit_top.sv
// ----------------------------------------------------------------------------
// Value mutation unit
// Applies one of eight mutation strategies to a 64-bit value per request.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request enters the input register, then the result
//   register behind one level of mux, mask and 64-bit add logic; m_tvalid
//   is high while the result register holds a result.
// Throughput: one request per cycle; s_tready drops only when both stages
//   hold a request and the result is not taken.
// Reset: arst_n clears both stage valids and loads page_size_log2 with 12.
module value_mutation_unit_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration: page_size_log2
	input  logic                                 cfg_we,
	input  logic [vmu_pkg::PAGE_LOG_W-1:0]       cfg_wdata,
	// request stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// value[63:0], variant[66:64], misalign_bit[68:67], flip_bit[73:69],
	// delta[81:74], subtract[82], zero pad above
	input  logic [vmu_pkg::IN_TDATA_W-1:0]       s_tdata,
	// kind[2:0]
	input  logic [vmu_pkg::IN_TUSER_W-1:0]       s_tuser,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// result[63:0]
	output logic [vmu_pkg::OUT_TDATA_W-1:0]      m_tdata
);
	import vmu_pkg::*;

	logic [PAGE_LOG_W-1:0] page_log2_q;

	req_t                  req_s1;
	kind_t                 kind_s1;
	logic                  valid_s1;
	logic [VALUE_W-1:0]    result_s2;
	logic                  valid_s2;

	logic                  adv_s2;
	logic                  adv_s1;
	logic [VALUE_W-1:0]    res_d;
	logic [VALUE_W-1:0]    v;
	logic [VALUE_W-1:0]    pmask;

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	assign v     = req_s1.value;
	assign pmask = (VALUE_W'(1) << page_log2_q) - VALUE_W'(1);

	always_comb begin
		res_d = v;
		unique case (kind_s1)
			KIND_TRUNC: begin
				if (req_s1.variant == VAR_W8) res_d = {56'd0, v[7:0]};
				else if (req_s1.variant == VAR_W16) res_d = {48'd0, v[15:0]};
				else if (req_s1.variant == VAR_W32) res_d = {32'd0, v[31:0]};
			end
			KIND_SET_MSB: begin
				if (req_s1.variant == VAR_W8) res_d = v | 64'h80;
				else if (req_s1.variant == VAR_W16) res_d = v | 64'h8000;
				else if (req_s1.variant == VAR_W32) res_d = v | 64'h8000_0000;
			end
			KIND_ALIGN: begin
				if (req_s1.variant == ALIGN_PAGE_DOWN) res_d = v & ~pmask;
				else if (req_s1.variant == ALIGN_PAGE_NEXT) res_d = (v | pmask) + VALUE_W'(1);
				else if (req_s1.variant == ALIGN_LINE) res_d = v & ~VALUE_W'(63);
				else if (req_s1.variant == ALIGN_MISALIGN &&
					req_s1.misalign_bit != MISALIGN_NONE)
					res_d = v | (VALUE_W'(1) << req_s1.misalign_bit);
			end
			KIND_INVERT: begin
				res_d = ~v;
			end
			KIND_BSWAP: begin
				if (req_s1.variant == SWAP_LOW32) res_d = {v[63:32], bswap32(v[31:0])};
				else if (req_s1.variant == SWAP_FULL64)
					res_d = {bswap32(v[31:0]), bswap32(v[63:32])};
			end
			KIND_FLIP: begin
				if ({2'b00, req_s1.flip_bit} < 7'(FLIP_BITS))
					res_d = v ^ (VALUE_W'(1) << req_s1.flip_bit);
			end
			KIND_DELTA: begin
				if (req_s1.subtract) res_d = v - {56'd0, req_s1.delta};
				else res_d = v + {56'd0, req_s1.delta};
			end
			KIND_EXTEND: begin
				if (req_s1.variant == EXT_ZERO8) res_d = {56'd0, v[7:0]};
				else if (req_s1.variant == EXT_ZERO16) res_d = {48'd0, v[15:0]};
				else if (req_s1.variant == EXT_ZERO32) res_d = {32'd0, v[31:0]};
				else if (req_s1.variant == EXT_SIGN8) res_d = {{56{v[7]}}, v[7:0]};
				else if (req_s1.variant == EXT_SIGN16) res_d = {{48{v[15]}}, v[15:0]};
				else if (req_s1.variant == EXT_SIGN32) res_d = {{32{v[31]}}, v[31:0]};
			end
			default: res_d = v;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_log2_q <= PAGE_LOG_RESET;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (cfg_we) page_log2_q <= cfg_wdata;
			if (adv_s1) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// payload stages, no reset
	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			req_s1  <= req_t'(s_tdata[REQ_W-1:0]);
			kind_s1 <= kind_t'(s_tuser);
		end
		if (adv_s2 && valid_s1) result_s2 <= res_d;
	end

endmodule
